// ----- sv/tprls_pkg.sv -----
// package for the two-parameter rls estimator: reset values, operation
// and operand codes, and the microprogram that sequences one update
// no dependencies
package tprls_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [16:0] LAMBDA_RESET = 17'd65209;
  localparam logic [30:0] INIT_COV_RESET = 31'd655360;
  localparam logic [30:0] INIT_EV_RESET = 31'd65536;
  localparam logic [16:0] LAMBDA_MIN = 17'd32768;
  localparam logic [16:0] LAMBDA_MAX = 17'd65536;

  // configuration register indexes
  localparam logic [1:0] CFG_LAMBDA = 2'd0;
  localparam logic [1:0] CFG_INIT_COV = 2'd1;
  localparam logic [1:0] CFG_INIT_EV = 2'd2;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_CHK, OP_END
  } op_t;

  typedef enum logic [4:0] {
    S_NONE, S_R, S_T, S_LAM, S_E, S_PP0, S_PP1, S_DEN, S_K0, S_K1, S_TMP, S_TMP2,
    S_G, S_O, S_C00, S_C01, S_C10, S_C11, S_EV, S_ALPHA, S_OMA,
    S_NG, S_NO, S_N00, S_N01, S_N10, S_N11, S_NEV
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t a;
    sel_t b;
    sel_t d;
  } instr_t;

  localparam int PC_W = 6;

  // one rls update: prediction error, p*phi, denominator, gains,
  // parameters, covariance and smoothed error variance
  function automatic instr_t prog(input logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      6'd0:  i = '{OP_MUL, S_G, S_T, S_TMP};
      6'd1:  i = '{OP_ADD, S_TMP, S_O, S_TMP};
      6'd2:  i = '{OP_SUB, S_R, S_TMP, S_E};
      6'd3:  i = '{OP_MUL, S_C00, S_T, S_TMP};
      6'd4:  i = '{OP_ADD, S_TMP, S_C01, S_PP0};
      6'd5:  i = '{OP_MUL, S_C10, S_T, S_TMP};
      6'd6:  i = '{OP_ADD, S_TMP, S_C11, S_PP1};
      6'd7:  i = '{OP_MUL, S_T, S_PP0, S_TMP};
      6'd8:  i = '{OP_ADD, S_TMP, S_PP1, S_TMP};
      6'd9:  i = '{OP_ADD, S_LAM, S_TMP, S_DEN};
      6'd10: i = '{OP_CHK, S_NONE, S_NONE, S_NONE};
      6'd11: i = '{OP_DIV, S_PP0, S_DEN, S_K0};
      6'd12: i = '{OP_DIV, S_PP1, S_DEN, S_K1};
      6'd13: i = '{OP_MUL, S_K0, S_E, S_TMP};
      6'd14: i = '{OP_ADD, S_G, S_TMP, S_NG};
      6'd15: i = '{OP_MUL, S_K1, S_E, S_TMP};
      6'd16: i = '{OP_ADD, S_O, S_TMP, S_NO};
      6'd17: i = '{OP_MUL, S_PP0, S_K0, S_TMP};
      6'd18: i = '{OP_SUB, S_C00, S_TMP, S_TMP};
      6'd19: i = '{OP_DIV, S_TMP, S_LAM, S_N00};
      6'd20: i = '{OP_MUL, S_PP0, S_K1, S_TMP};
      6'd21: i = '{OP_SUB, S_C01, S_TMP, S_TMP};
      6'd22: i = '{OP_DIV, S_TMP, S_LAM, S_N01};
      6'd23: i = '{OP_MUL, S_PP1, S_K0, S_TMP};
      6'd24: i = '{OP_SUB, S_C10, S_TMP, S_TMP};
      6'd25: i = '{OP_DIV, S_TMP, S_LAM, S_N10};
      6'd26: i = '{OP_MUL, S_PP1, S_K1, S_TMP};
      6'd27: i = '{OP_SUB, S_C11, S_TMP, S_TMP};
      6'd28: i = '{OP_DIV, S_TMP, S_LAM, S_N11};
      6'd29: i = '{OP_MUL, S_OMA, S_EV, S_TMP2};
      6'd30: i = '{OP_MUL, S_ALPHA, S_E, S_TMP};
      6'd31: i = '{OP_MUL, S_TMP, S_E, S_TMP};
      6'd32: i = '{OP_ADD, S_TMP2, S_TMP, S_NEV};
      default: i = '{OP_END, S_NONE, S_NONE, S_NONE};
    endcase
    return i;
  endfunction

endpackage

// ----- sv/two_param_rls_estimator.sv -----
// two-parameter recursive least squares estimator, bit-serial datapath
// depends on tprls_pkg
//
// Fits residual = gain*thrust + offset with a forgetting factor in signed
// fixed point (FRAC_BITS fraction bits, 32-bit words). One word in gives one
// word out holding the state after it. A restart word skips the microprogram. An
// update runs a microprogram on one shared bit-serial multiplier and one shared
// restoring divider: 13 products, 6 quotients, and adds, subtracts, a check and
// an end step; a zero denominator or an overflow in the first part ends the word
// at the check step. The next word is taken once the current one has left the
// sequencer, while its result may still wait in the output register.
// Configuration writes are always taken.
module two_param_rls_estimator
  import tprls_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] residual,
  input  logic signed [18:0] thrust,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] gain_estimate,
  output logic signed [31:0] offset_estimate,
  output logic signed [31:0] gain_variance,
  output logic [30:0]        error_variance,
  output logic               update_skipped,
  output logic               was_restarted
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW);
  localparam int LSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int RSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic signed [31:0] ALPHA = 32'(((64'sd1 <<< FRAC_BITS) + 50) / 100);
  localparam logic signed [31:0] OMA = 32'((64'sd1 <<< FRAC_BITS)) - ALPHA;
  localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [64:0] SMAX = 65'sd2147483647;
  localparam logic signed [64:0] SMIN = -65'sd2147483648;
  localparam logic [DW-1:0] QPOS = DW'(32'h7fffffff);
  localparam logic [DW-1:0] QNEG = DW'(33'h080000000);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_MUL_RUN, ST_MUL_FIX, ST_MUL_RND, ST_DIV_RUN, ST_DIV_FIX, ST_DONE
  } state_t;

  state_t state;
  logic [PC_W-1:0] pc;
  logic [CW-1:0] cnt;
  logic ovf;
  logic skip_flag;
  logic rst_flag;

  logic [16:0] lambda_cfg;
  logic [30:0] init_cov;
  logic [30:0] init_ev;

  logic signed [31:0] gain, offset, cov_gg, cov_go, cov_og, cov_oo, smoothed_error;
  logic signed [31:0] r, t, lam, e, pp0, pp1, den, k0, k1, tmp, tmp2;
  logic signed [31:0] ng, no_, n00, n01, n10, n11, nev;

  // serial arithmetic registers
  logic [31:0] ma, hi, lo, dvs;
  logic [32:0] rem;
  logic [DW-1:0] dq;
  logic signed [63:0] prod;
  logic neg;
  logic [PC_W-1:0] pc_next;

  instr_t ins;
  logic signed [31:0] opa, opb;
  logic [31:0] abs_a, abs_b;
  logic signed [64:0] sum_ext;
  logic signed [31:0] sum_sat;
  logic sum_ovf;
  logic [32:0] madd;
  logic [32:0] trial;
  logic signed [64:0] rnd;
  logic signed [64:0] rnd_sh;
  logic [16:0] lam_c;
  logic [31:0] lam_full;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == ST_IDLE);
  assign ins = prog(pc);
  assign pc_next = pc + PC_W'(1);

  // operand select
  function automatic logic signed [31:0] pick(input sel_t s,
      input logic signed [31:0] v_r, v_t, v_lam, v_e, v_pp0, v_pp1, v_den,
      v_k0, v_k1, v_tmp, v_tmp2, v_g, v_o, v_c00, v_c01, v_c10, v_c11, v_ev);
    logic signed [31:0] v;
    case (s)
      S_R: v = v_r;
      S_T: v = v_t;
      S_LAM: v = v_lam;
      S_E: v = v_e;
      S_PP0: v = v_pp0;
      S_PP1: v = v_pp1;
      S_DEN: v = v_den;
      S_K0: v = v_k0;
      S_K1: v = v_k1;
      S_TMP: v = v_tmp;
      S_TMP2: v = v_tmp2;
      S_G: v = v_g;
      S_O: v = v_o;
      S_C00: v = v_c00;
      S_C01: v = v_c01;
      S_C10: v = v_c10;
      S_C11: v = v_c11;
      S_EV: v = v_ev;
      S_ALPHA: v = ALPHA;
      S_OMA: v = OMA;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign opa = pick(ins.a, r, t, lam, e, pp0, pp1, den, k0, k1, tmp, tmp2,
                    gain, offset, cov_gg, cov_go, cov_og, cov_oo, smoothed_error);
  assign opb = pick(ins.b, r, t, lam, e, pp0, pp1, den, k0, k1, tmp, tmp2,
                    gain, offset, cov_gg, cov_go, cov_og, cov_oo, smoothed_error);
  assign abs_a = opa[31] ? 32'(-opa) : 32'(opa);
  assign abs_b = opb[31] ? 32'(-opb) : 32'(opb);

  // add and subtract with saturation, or product rounding
  always_comb begin
    rnd = {prod[63], prod} + HALF;
    rnd_sh = rnd >>> FRAC_BITS;
    if (state == ST_MUL_RND) begin
      sum_ext = rnd_sh;
    end else if (ins.op == OP_SUB) begin
      sum_ext = 65'(opa) - 65'(opb);
    end else begin
      sum_ext = 65'(opa) + 65'(opb);
    end
    sum_ovf = (sum_ext > SMAX) || (sum_ext < SMIN);
    if (sum_ext > SMAX) begin
      sum_sat = 32'sh7fffffff;
    end else if (sum_ext < SMIN) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = sum_ext[31:0];
    end
  end

  // one shift-add step and one restoring-divide step
  assign madd = {1'b0, hi} + (lo[0] ? {1'b0, ma} : 33'd0);
  assign trial = {rem[31:0], dq[DW-1]};

  // forgetting factor clamp and scaling
  always_comb begin
    if (lambda_cfg < LAMBDA_MIN) begin
      lam_c = LAMBDA_MIN;
    end else if (lambda_cfg > LAMBDA_MAX) begin
      lam_c = LAMBDA_MAX;
    end else begin
      lam_c = lambda_cfg;
    end
    lam_full = ({15'd0, lam_c} << LSH) >> RSH;
  end

  // sequencer, datapath and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= '0;
      cnt <= '0;
      ovf <= 1'b0;
      skip_flag <= 1'b0;
      rst_flag <= 1'b0;
      out_valid <= 1'b0;
      lambda_cfg <= LAMBDA_RESET;
      init_cov <= INIT_COV_RESET;
      init_ev <= INIT_EV_RESET;
      gain <= '0;
      offset <= '0;
      cov_gg <= {1'b0, INIT_COV_RESET};
      cov_go <= '0;
      cov_og <= '0;
      cov_oo <= {1'b0, INIT_COV_RESET};
      smoothed_error <= {1'b0, INIT_EV_RESET};
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LAMBDA: lambda_cfg <= {cfg_data[16:0]};
          CFG_INIT_COV: init_cov <= cfg_data;
          CFG_INIT_EV: init_ev <= cfg_data;
          default: ;
        endcase
      end
      // output register empties unless refilled below
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            r <= residual;
            t <= 32'(thrust);
            lam <= lam_full;
            pc <= '0;
            ovf <= 1'b0;
            skip_flag <= 1'b0;
            rst_flag <= action;
            if (action) begin
              gain <= '0;
              offset <= '0;
              cov_gg <= {1'b0, init_cov};
              cov_go <= '0;
              cov_og <= '0;
              cov_oo <= {1'b0, init_cov};
              smoothed_error <= {1'b0, init_ev};
              state <= ST_DONE;
            end else begin
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          case (ins.op)
            OP_ADD, OP_SUB: begin
              ovf <= ovf | sum_ovf;
              case (ins.d)
                S_TMP: tmp <= sum_sat;
                S_E: e <= sum_sat;
                S_PP0: pp0 <= sum_sat;
                S_PP1: pp1 <= sum_sat;
                S_DEN: den <= sum_sat;
                S_NG: ng <= sum_sat;
                S_NO: no_ <= sum_sat;
                default: nev <= sum_sat;
              endcase
              pc <= pc_next;
            end
            OP_MUL: begin
              ma <= abs_a;
              lo <= abs_b;
              hi <= '0;
              neg <= opa[31] ^ opb[31];
              cnt <= '0;
              state <= ST_MUL_RUN;
            end
            OP_DIV: begin
              dq <= DW'(abs_a) << FRAC_BITS;
              dvs <= abs_b;
              rem <= '0;
              neg <= opa[31] ^ opb[31];
              cnt <= '0;
              state <= ST_DIV_RUN;
            end
            OP_CHK: begin
              if (ovf) begin
                gain <= '0;
                offset <= '0;
                cov_gg <= {1'b0, init_cov};
                cov_go <= '0;
                cov_og <= '0;
                cov_oo <= {1'b0, init_cov};
                smoothed_error <= {1'b0, init_ev};
                rst_flag <= 1'b1;
                state <= ST_DONE;
              end else if (den == 32'sd0) begin
                skip_flag <= 1'b1;
                state <= ST_DONE;
              end else begin
                pc <= pc_next;
              end
            end
            default: begin
              if (ovf) begin
                gain <= '0;
                offset <= '0;
                cov_gg <= {1'b0, init_cov};
                cov_go <= '0;
                cov_og <= '0;
                cov_oo <= {1'b0, init_cov};
                smoothed_error <= {1'b0, init_ev};
                rst_flag <= 1'b1;
              end else begin
                gain <= ng;
                offset <= no_;
                cov_gg <= n00;
                cov_go <= n01;
                cov_og <= n10;
                cov_oo <= n11;
                smoothed_error <= nev;
              end
              state <= ST_DONE;
            end
          endcase
        end
        ST_MUL_RUN: begin
          hi <= madd[32:1];
          lo <= {madd[0], lo[31:1]};
          cnt <= cnt + CW'(1);
          if (cnt == CW'(31)) begin
            state <= ST_MUL_FIX;
          end
        end
        ST_MUL_FIX: begin
          prod <= neg ? -$signed({hi, lo}) : $signed({hi, lo});
          state <= ST_MUL_RND;
        end
        ST_MUL_RND: begin
          ovf <= ovf | sum_ovf;
          case (ins.d)
            S_TMP2: tmp2 <= sum_sat;
            default: tmp <= sum_sat;
          endcase
          pc <= pc_next;
          state <= ST_FETCH;
        end
        ST_DIV_RUN: begin
          if (trial >= {1'b0, dvs}) begin
            rem <= trial - {1'b0, dvs};
            dq <= {dq[DW-2:0], 1'b1};
          end else begin
            rem <= trial;
            dq <= {dq[DW-2:0], 1'b0};
          end
          cnt <= cnt + CW'(1);
          if (cnt == CW'(DW - 1)) begin
            state <= ST_DIV_FIX;
          end
        end
        ST_DIV_FIX: begin
          logic signed [31:0] q;
          q = neg ? 32'(-$signed(dq[31:0])) : $signed(dq[31:0]);
          if (neg && (dq > QNEG)) begin
            q = 32'sh80000000;
            ovf <= 1'b1;
          end else if (!neg && (dq > QPOS)) begin
            q = 32'sh7fffffff;
            ovf <= 1'b1;
          end
          case (ins.d)
            S_K0: k0 <= q;
            S_K1: k1 <= q;
            S_N00: n00 <= q;
            S_N01: n01 <= q;
            S_N10: n10 <= q;
            default: n11 <= q;
          endcase
          pc <= pc_next;
          state <= ST_FETCH;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            gain_estimate <= gain;
            offset_estimate <= offset;
            gain_variance <= cov_gg;
            error_variance <= smoothed_error[30:0];
            update_skipped <= skip_flag;
            was_restarted <= rst_flag;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(update_skipped && was_restarted))
    else $error("skip and restart flagged together");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action) |=> (gain == 32'sd0 && offset == 32'sd0))
    else $error("restart word left parameters set");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH && ins.op == OP_DIV) |-> (opb != 32'sd0))
    else $error("divider started with zero divisor");

  a_skip_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH && ins.op == OP_CHK && !ovf && den == 32'sd0)
      |=> $stable(gain) && $stable(cov_gg))
    else $error("skipped update changed state");

endmodule
